/* src/cspu_pkg.sv */
// Package for the CAN signal pack/unpack unit: field widths, command and
// register codes, the item, result and configuration structs, byte swap helper.
// No dependencies.
package cspu_pkg;

   localparam int PAYLOAD_W  = 64;
   localparam int RAW_W      = 64;
   localparam int START_W    = 6;
   localparam int LEN_W      = 7;
   localparam int FLEN_W     = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;
   localparam int FRAME_BYTES_MAX = 8;
   localparam int SIG_LEN_MAX     = 64;

   typedef enum logic {
      CMD_DECODE = 1'b0,
      CMD_ENCODE = 1'b1
   } cmd_type;

   typedef enum logic {
      ORDER_INTEL    = 1'b0,
      ORDER_MOTOROLA = 1'b1
   } order_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_BIT    = 2'd0,
      CSR_BIT_LENGTH   = 2'd1,
      CSR_BYTE_ORDER   = 2'd2,
      CSR_VALUE_SIGNED = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [START_W-1:0] start_bit;
      logic [LEN_W-1:0]   bit_length;
      order_type          byte_order;
      logic               value_signed;
   } cfg_type;

   typedef struct packed {
      cmd_type               command;
      logic [PAYLOAD_W-1:0]  payload_in;
      logic [FLEN_W-1:0]     frame_length;
      logic signed [RAW_W-1:0] raw_in;
   } item_type;

   typedef struct packed {
      cmd_type                 command;
      logic signed [RAW_W-1:0] raw_value;
      logic [PAYLOAD_W-1:0]    payload_out;
   } result_type;

   // Byte 0 <-> byte 7 and so on; maps Motorola bit order onto a straight
   // bit line where the signal MSB sits at the higher position.
   function automatic logic [PAYLOAD_W-1:0] byte_swap(input logic [PAYLOAD_W-1:0] d);
      logic [PAYLOAD_W-1:0] r;
      for (int k = 0; k < FRAME_BYTES_MAX; k++) begin
         r[8*k +: 8] = d[8*(FRAME_BYTES_MAX-1-k) +: 8];
      end
      return r;
   endfunction

endpackage

/* src/cspu_req_if.sv */
// Request channel of the CAN signal pack/unpack unit: valid/ready plus item
// fields. Depends on cspu_pkg for widths.
interface cspu_req_if import cspu_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    command;
   logic [PAYLOAD_W-1:0]    payload_in;
   logic [FLEN_W-1:0]       frame_length;
   logic signed [RAW_W-1:0] raw_in;

   modport source (output valid, command, payload_in, frame_length, raw_in,
                   input ready);
   modport sink   (input valid, command, payload_in, frame_length, raw_in,
                   output ready);
endinterface

/* src/cspu_rsp_if.sv */
// Response channel of the CAN signal pack/unpack unit: valid/ready plus
// result fields. Depends on cspu_pkg for widths.
interface cspu_rsp_if import cspu_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [RAW_W-1:0] raw_value;
   logic [PAYLOAD_W-1:0]    payload_out;

   modport source (output valid, raw_value, payload_out, input ready);
   modport sink   (input valid, raw_value, payload_out, output ready);
endinterface

/* src/cspu_csr.sv */
// Configuration registers of the CAN signal pack/unpack unit.
// Depends on cspu_pkg for the register codes and the cfg_type struct.
module cspu_csr import cspu_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_START_BIT:    cfg_in.start_bit    = csr_wdata[START_W-1:0];
            CSR_BIT_LENGTH:   cfg_in.bit_length   = csr_wdata[LEN_W-1:0];
            CSR_BYTE_ORDER:   cfg_in.byte_order   = order_type'(csr_wdata[0]);
            CSR_VALUE_SIGNED: cfg_in.value_signed = csr_wdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_bit    <= '0;
         cfg_ff.bit_length   <= LEN_W'(8);
         cfg_ff.byte_order   <= ORDER_INTEL;
         cfg_ff.value_signed <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* src/cspu_datapath.sv */
// Signal extract/insert logic of the CAN signal pack/unpack unit: one item in,
// one result out, purely combinational. Depends on cspu_pkg.
module cspu_datapath import cspu_pkg::*; #(
   parameter int PAYLOAD_BYTES = 8
) (
   input  cfg_type    cfg,
   input  item_type   item,
   output result_type result
);

   localparam int BYTE_CAP = (PAYLOAD_BYTES < FRAME_BYTES_MAX) ? PAYLOAD_BYTES
                                                                : FRAME_BYTES_MAX;

   logic [LEN_W-1:0]     len;
   logic [PAYLOAD_W-1:0] len_mask;
   logic [FLEN_W-1:0]    nbytes;
   logic [PAYLOAD_W-1:0] valid_mask;
   logic                 motorola;
   logic [PAYLOAD_W-1:0] line;
   logic [PAYLOAD_W-1:0] line_mask;
   logic [START_W-1:0]   start_lin;
   logic signed [7:0]    base;
   logic                 base_neg;
   logic [6:0]           amt;
   logic [PAYLOAD_W-1:0] dec_shift;
   logic [PAYLOAD_W-1:0] dec_val;
   logic [PAYLOAD_W-1:0] raw_masked;
   logic [PAYLOAD_W-1:0] placed;
   logic [PAYLOAD_W-1:0] field_mask;
   logic [PAYLOAD_W-1:0] line_new;
   logic [PAYLOAD_W-1:0] enc_payload;

   always_comb begin
      len = (cfg.bit_length > LEN_W'(SIG_LEN_MAX)) ? LEN_W'(SIG_LEN_MAX) : cfg.bit_length;
      len_mask = len[6] ? '1 : ((PAYLOAD_W'(1) << len[5:0]) - PAYLOAD_W'(1));

      nbytes = (int'(item.frame_length) > BYTE_CAP) ? FLEN_W'(BYTE_CAP)
                                                    : item.frame_length;
      for (int k = 0; k < FRAME_BYTES_MAX; k++) begin
         valid_mask[8*k +: 8] = (FLEN_W'(k) < nbytes) ? 8'hFF : 8'h00;
      end

      // Motorola: byte swap puts the walk on one straight line, MSB first
      // at line position 63 - (start ^ 7).
      motorola  = (cfg.byte_order == ORDER_MOTOROLA);
      line      = motorola ? byte_swap(item.payload_in) : item.payload_in;
      line_mask = motorola ? byte_swap(valid_mask) : valid_mask;
      start_lin = cfg.start_bit ^ START_W'(7);

      if (motorola) begin
         base = 8'sd64 - $signed({2'b00, start_lin}) - $signed({1'b0, len});
      end else begin
         base = $signed({2'b00, cfg.start_bit});
      end
      base_neg = base[7];
      amt      = base_neg ? 7'(-base) : base[6:0];

      // Decode: signal bit v sits at line position base + v.
      dec_shift = base_neg ? ((line & line_mask) << amt) : ((line & line_mask) >> amt);
      dec_val   = dec_shift & len_mask;
      if (cfg.value_signed && (len != '0) && !len[6] && dec_val[len[5:0] - 6'd1]) begin
         dec_val = dec_val | ~len_mask;
      end

      // Encode: overwrite only the field bits that land inside the frame.
      raw_masked  = item.raw_in & len_mask;
      placed      = base_neg ? (raw_masked >> amt) : (raw_masked << amt);
      field_mask  = (base_neg ? (len_mask >> amt) : (len_mask << amt)) & line_mask;
      line_new    = (line & ~field_mask) | (placed & field_mask);
      enc_payload = motorola ? byte_swap(line_new) : line_new;

      result.command = item.command;
      if (item.command == CMD_ENCODE) begin
         result.raw_value   = '0;
         result.payload_out = enc_payload;
      end else begin
         result.raw_value   = dec_val;
         result.payload_out = item.payload_in;
      end
   end

endmodule

/* src/can_signal_pack_unpack_unit.sv */
// CAN signal pack/unpack unit. Decode pulls the configured signal (start bit,
// length, Intel or Motorola order, optional sign extension) out of an 8-byte
// payload; encode writes the masked raw value into a copy of the payload.
// Bits past the frame length read as zero and are never written. One item is
// taken per clock unless both stages are full and the response is stalled;
// an item passes the input register, then the result register. The user must
// write the configuration registers through the csr_ port only while no item
// is in flight; the unit itself does not enforce this.
module can_signal_pack_unpack_unit import cspu_pkg::*; #(
   parameter int PAYLOAD_BYTES = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   cspu_req_if.sink              req_chan,
   cspu_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg;
   item_type   item_ff;
   item_type   item_in;
   logic       item_valid_ff;
   result_type res_ff;
   result_type res_in;
   logic       res_valid_ff;
   logic       res_en;
   logic       item_en;

   cspu_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cspu_datapath #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_datapath (
      .cfg    (cfg),
      .item   (item_ff),
      .result (res_in)
   );

   // Advance the result stage when empty or taken; input stage follows.
   assign res_en  = !res_valid_ff || rsp_chan.ready;
   assign item_en = !item_valid_ff || res_en;

   assign req_chan.ready = item_en;

   always_comb begin
      item_in.command      = cmd_type'(req_chan.command);
      item_in.payload_in   = req_chan.payload_in;
      item_in.frame_length = req_chan.frame_length;
      item_in.raw_in       = req_chan.raw_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         res_valid_ff  <= 1'b0;
      end else begin
         if (item_en) begin
            item_valid_ff <= req_chan.valid;
         end
         if (res_en) begin
            res_valid_ff <= item_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_en && req_chan.valid) begin
         item_ff <= item_in;
      end
      if (res_en && item_valid_ff) begin
         res_ff <= res_in;
      end
   end

   assign rsp_chan.valid       = res_valid_ff;
   assign rsp_chan.raw_value   = res_ff.raw_value;
   assign rsp_chan.payload_out = res_ff.payload_out;

   // Backpressure only when both stages hold items and the result is stalled.
   a_ready_low_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (item_valid_ff && rsp_chan.valid && !rsp_chan.ready))
      else $error("request stalled while a stage is free");

   a_encode_zero_raw: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && res_ff.command == CMD_ENCODE) |-> (rsp_chan.raw_value == '0))
      else $error("encode result carries a nonzero raw value");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_chan.valid && !item_valid_ff))
      else $error("pipeline not empty after reset");

endmodule

/* tb/sv/can_signal_pack_unpack_unit_test.sv */
// Testbench for can_signal_pack_unpack_unit: a directed table, then random phases under
// random configurations. Results are checked against table values or a local predictor.
// Depends on cspu_pkg, cspu_req_if, cspu_rsp_if and the unit itself.
module can_signal_pack_unpack_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import cspu_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned DRAIN_CYCLES = 6;
   localparam int unsigned PHASE_COUNT  = 12;
   localparam int unsigned PHASE_ITEMS  = 125;
   localparam int unsigned PRINT_CAP    = 40;

   typedef struct packed {
      logic [RAW_W-1:0]     raw_value;
      logic [PAYLOAD_W-1:0] payload_out;
   } signal_result_type;

   typedef struct {
      cfg_type           cfg;
      item_type          item;
      bit                typed;
      signal_result_type result;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   cspu_req_if req_chan ();
   cspu_rsp_if rsp_chan ();

   can_signal_pack_unpack_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   signal_result_type pending_results[$];
   signal_result_type oldest_result;
   stim_row_type      stim_rows[$];
   cfg_type           active_cfg;
   int unsigned       error_count;
   int unsigned       cycle_count;
   int unsigned       burst_left;
   int unsigned       rx_mode;
   int unsigned       rx_mode_left;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Signal extraction / insertion, walked bit by bit in the configured order.
   function automatic signal_result_type pack_unpack_signal(input item_type it,
                                                            input cfg_type c);
      signal_result_type r;
      int unsigned len;
      int unsigned limit;
      int unsigned pos;
      int unsigned vbit;
      bit motorola;
      bit encode;
      logic [RAW_W-1:0]     raw;
      logic [RAW_W-1:0]     value;
      logic [PAYLOAD_W-1:0] payload;
      len      = (c.bit_length > SIG_LEN_MAX) ? SIG_LEN_MAX : c.bit_length;
      limit    = 8 * ((it.frame_length > FRAME_BYTES_MAX) ? FRAME_BYTES_MAX
                                                          : it.frame_length);
      motorola = (c.byte_order == ORDER_MOTOROLA);
      encode   = (it.command == CMD_ENCODE);
      pos      = c.start_bit;
      raw      = it.raw_in;
      payload  = it.payload_in;
      value    = '0;
      if (encode && len < 64) raw &= (64'd1 << len) - 64'd1;
      for (int unsigned i = 0; i < len; i++) begin
         vbit = motorola ? (len - 1 - i) : i;
         if (pos < limit && pos < 64) begin
            if (encode) payload[pos] = raw[vbit];
            else if (payload[pos]) value[vbit] = 1'b1;
         end
         // Motorola: step toward bit 0 of the byte, then jump to bit 7 of the next one
         if (!motorola) pos = pos + 1;
         else if (pos % 8 == 0) pos = pos + 15;
         else pos = pos - 1;
      end
      if (!encode && c.value_signed && len >= 1 && len < 64 && value[len-1])
         value |= ~((64'd1 << len) - 64'd1);
      r.raw_value   = encode ? '0 : value;
      r.payload_out = payload;
      return r;
   endfunction

   function automatic cfg_type make_cfg(input int unsigned start, input int unsigned len,
                                        input order_type order, input bit sgn);
      cfg_type c;
      c.start_bit    = start[START_W-1:0];
      c.bit_length   = len[LEN_W-1:0];
      c.byte_order   = order;
      c.value_signed = sgn;
      return c;
   endfunction

   function automatic item_type make_item(input cmd_type cmd, input logic [63:0] payload,
                                          input logic [FLEN_W-1:0] flen,
                                          input logic [63:0] raw);
      item_type it;
      it.command      = cmd;
      it.payload_in   = payload;
      it.frame_length = flen;
      it.raw_in       = raw;
      return it;
   endfunction

   function automatic void add_row(input int unsigned start, input int unsigned len,
                                   input order_type order, input bit sgn,
                                   input cmd_type cmd, input logic [63:0] payload,
                                   input logic [FLEN_W-1:0] flen, input logic [63:0] raw,
                                   input bit typed = 1'b0,
                                   input logic [63:0] exp_raw = '0,
                                   input logic [63:0] exp_payload = '0);
      stim_row_type row;
      row.cfg                = make_cfg(start, len, order, sgn);
      row.item               = make_item(cmd, payload, flen, raw);
      row.typed              = typed;
      row.result.raw_value   = exp_raw;
      row.result.payload_out = exp_payload;
      stim_rows.push_back(row);
   endfunction

   function automatic cfg_type random_config();
      int unsigned start;
      int unsigned len;
      case ($urandom_range(0, 5))
         0:       start = 0;
         1:       start = 63;
         default: start = $urandom_range(0, 63);
      endcase
      case ($urandom_range(0, 9))
         0:       len = 0;
         1:       len = 1;
         2:       len = 64;
         3:       len = $urandom_range(65, 127);
         default: len = $urandom_range(1, 64);
      endcase
      return make_cfg(start, len, order_type'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
   endfunction

   function automatic item_type random_item();
      logic [63:0]       payload;
      logic [63:0]       raw;
      logic [FLEN_W-1:0] flen;
      case ($urandom_range(0, 9))
         0:       payload = '0;
         1:       payload = '1;
         default: payload = {$urandom, $urandom};
      endcase
      case ($urandom_range(0, 9))
         0, 1:    flen = FLEN_W'($urandom_range(0, 7));
         2:       flen = FLEN_W'($urandom_range(9, 15));
         default: flen = FLEN_W'(FRAME_BYTES_MAX);
      endcase
      case ($urandom_range(0, 9))
         0:       raw = 64'h8000_0000_0000_0000;
         1:       raw = 64'h7FFF_FFFF_FFFF_FFFF;
         2:       raw = 64'($urandom_range(0, 255));
         3:       raw = -64'($urandom_range(1, 256));
         default: raw = {$urandom, $urandom};
      endcase
      return make_item(cmd_type'($urandom_range(0, 1)), payload, flen, raw);
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      if (error_count <= PRINT_CAP)
         $display("ERROR %0t: %s got %h expected %h", $time, what, got, want);
   endtask

   task automatic send_transfer(input item_type it, input signal_result_type want);
      int unsigned gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_chan.valid        <= 1'b1;
      req_chan.command      <= it.command;
      req_chan.payload_in   <= it.payload_in;
      req_chan.frame_length <= it.frame_length;
      req_chan.raw_in       <= it.raw_in;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pending_results.push_back(want);
   endtask

   // Hold the sender until every pending result has come back.
   task automatic drain_results();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
   endtask

   // Unused upper data bits carry junk; the unit must drop them.
   task automatic apply_config(input cfg_type c);
      logic [CSR_DATA_W-1:0] junk;
      drain_results();
      junk = CSR_DATA_W'($urandom);
      write_register(CSR_START_BIT, {junk[6], c.start_bit});
      write_register(CSR_BIT_LENGTH, c.bit_length);
      write_register(CSR_BYTE_ORDER, {junk[5:0], c.byte_order});
      write_register(CSR_VALUE_SIGNED, {junk[6:1], c.value_signed});
      @(negedge clock);
      csr_we <= 1'b0;
      active_cfg = c;
   endtask

   always @(negedge clock) begin
      if (rx_mode_left == 0) begin
         rx_mode      = $urandom_range(0, 3);
         rx_mode_left = $urandom_range(20, 200);
      end
      rx_mode_left--;
      case (rx_mode)
         0:       rsp_chan.ready <= 1'b1;
         1:       rsp_chan.ready <= ($urandom_range(0, 3) != 0);
         2:       rsp_chan.ready <= ($urandom_range(0, 3) == 0);
         default: rsp_chan.ready <= ((rx_mode_left % 7) < 4);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result, payload_out", rsp_chan.payload_out, '0);
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_chan.raw_value !== oldest_result.raw_value)
               report_mismatch("raw_value", rsp_chan.raw_value, oldest_result.raw_value);
            if (rsp_chan.payload_out !== oldest_result.payload_out)
               report_mismatch("payload_out", rsp_chan.payload_out,
                               oldest_result.payload_out);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      cfg_type  phase_cfg;
      item_type it;
      error_count           = 0;
      cycle_count           = 0;
      burst_left            = 0;
      rx_mode               = 0;
      rx_mode_left          = 0;
      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_index             = CSR_START_BIT;
      csr_wdata             = '0;
      req_chan.valid        = 1'b0;
      req_chan.command      = CMD_DECODE;
      req_chan.payload_in   = '0;
      req_chan.frame_length = '0;
      req_chan.raw_in       = '0;
      rsp_chan.ready        = 1'b0;
      active_cfg            = make_cfg(0, 8, ORDER_INTEL, 1'b0);

      // Reset values, then length, start bit and frame length extremes.
      add_row(0, 8, ORDER_INTEL, 0, CMD_DECODE, 64'h0123_4567_89AB_CDEF, 8, '0,
              1, 64'hEF, 64'h0123_4567_89AB_CDEF);
      add_row(0, 8, ORDER_INTEL, 0, CMD_ENCODE, '0, 8, 64'h1FF, 1, '0, 64'hFF);
      add_row(0, 8, ORDER_INTEL, 0, CMD_DECODE, '1, 0, '1, 1, '0, '1);
      add_row(0, 64, ORDER_INTEL, 1, CMD_DECODE, '1, 8, '0, 1, '1, '1);
      add_row(0, 64, ORDER_INTEL, 1, CMD_ENCODE, '0, 8, 64'h8000_0000_0000_0001,
              1, '0, 64'h8000_0000_0000_0001);
      add_row(0, 64, ORDER_INTEL, 1, CMD_ENCODE, '1, 4, '0,
              1, '0, 64'hFFFF_FFFF_0000_0000);
      add_row(63, 1, ORDER_INTEL, 1, CMD_DECODE, 64'h8000_0000_0000_0000, 8, '0,
              1, '1, 64'h8000_0000_0000_0000);
      add_row(63, 1, ORDER_INTEL, 1, CMD_DECODE, 64'h8000_0000_0000_0000, 7, '0,
              1, '0, 64'h8000_0000_0000_0000);
      add_row(63, 1, ORDER_INTEL, 1, CMD_ENCODE, '0, 8, '1,
              1, '0, 64'h8000_0000_0000_0000);
      add_row(10, 0, ORDER_INTEL, 1, CMD_DECODE, '1, 8, '0, 1, '0, '1);
      add_row(10, 0, ORDER_INTEL, 1, CMD_ENCODE, 64'h5555_5555_5555_5555, 8, '1,
              1, '0, 64'h5555_5555_5555_5555);
      add_row(0, 127, ORDER_INTEL, 0, CMD_DECODE, 64'hFEDC_BA98_7654_3210, 15, '0,
              1, 64'hFEDC_BA98_7654_3210, 64'hFEDC_BA98_7654_3210);
      add_row(0, 127, ORDER_INTEL, 0, CMD_ENCODE, '0, 8, 64'h7FFF_FFFF_FFFF_FFFF,
              1, '0, 64'h7FFF_FFFF_FFFF_FFFF);
      // Motorola walks, byte jumps and signals running off the frame.
      add_row(7, 8, ORDER_MOTOROLA, 0, CMD_DECODE, 64'h0123_4567_89AB_CDEF, 8, '0);
      add_row(7, 16, ORDER_MOTOROLA, 0, CMD_DECODE, 64'h0123_4567_89AB_CDEF, 8, '0);
      add_row(7, 16, ORDER_MOTOROLA, 0, CMD_ENCODE, '1, 8, 64'hA55A);
      add_row(0, 12, ORDER_MOTOROLA, 1, CMD_DECODE, 64'h0000_0000_00E0_FF81, 3, '0);
      add_row(0, 12, ORDER_MOTOROLA, 1, CMD_ENCODE, '0, 2, -64'sd3);
      add_row(63, 64, ORDER_MOTOROLA, 1, CMD_DECODE, 64'hA5C3_0F96_5A3C_F069, 8, '0);
      add_row(63, 64, ORDER_MOTOROLA, 1, CMD_ENCODE, '0, 8, 64'h8000_0000_0000_0000);
      add_row(20, 16, ORDER_INTEL, 0, CMD_DECODE, '1, 3, '0);
      add_row(20, 16, ORDER_INTEL, 0, CMD_ENCODE, '0, 3, '1);
      add_row(4, 12, ORDER_INTEL, 1, CMD_DECODE, 64'h0000_0000_0000_8000, 9, '0);
      add_row(4, 12, ORDER_INTEL, 1, CMD_ENCODE, '1, 8, 64'h8000_0000_0000_0000);
      add_row(56, 8, ORDER_INTEL, 1, CMD_DECODE, 64'hFF00_0000_0000_0000, 8, '0);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) begin
         if (stim_rows[i].cfg != active_cfg) apply_config(stim_rows[i].cfg);
         send_transfer(stim_rows[i].item,
                       stim_rows[i].typed ? stim_rows[i].result
                                          : pack_unpack_signal(stim_rows[i].item,
                                                               active_cfg));
      end

      for (int unsigned ph = 0; ph < PHASE_COUNT; ph++) begin
         case (ph)
            0:       phase_cfg = make_cfg(63, 64, ORDER_MOTOROLA, 1'b1);
            1:       phase_cfg = make_cfg(0, 1, ORDER_INTEL, 1'b0);
            default: phase_cfg = random_config();
         endcase
         apply_config(phase_cfg);
         for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
            it = random_item();
            send_transfer(it, pack_unpack_signal(it, active_cfg));
            if (ph == 3 && n == PHASE_ITEMS / 2) drain_results();
         end
      end

      drain_results();
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
